[rtl/core/bracket_balance_checker_core_macros.svh]
// assertion macros shared by the bracket balance checker core
// no dependencies; expects clk and arst_n in the including scope
`ifndef BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH

// expression must hold on every clock edge out of reset
`define BBC_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bbc_pkg.sv]
// types, codes and constants of the bracket balance checker core
// no dependencies
`timescale 1ns / 1ps

package bbc_pkg;

	// default stack depth and queue sizes
	localparam int STACK_DEPTH_DEF = 64;
	localparam int CMD_Q_DEPTH     = 4;
	localparam int RES_Q_DEPTH     = 2;

	// bracket characters
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;

	// bracket types as kept on the stack
	localparam int BT_W = 2;
	localparam logic [BT_W-1:0] BT_PAREN  = 2'd0;
	localparam logic [BT_W-1:0] BT_SQUARE = 2'd1;
	localparam logic [BT_W-1:0] BT_CURLY  = 2'd2;

	// command kinds from the classifier
	localparam logic [1:0] KIND_OPEN  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	// failure reasons
	localparam logic [1:0] REASON_OK       = 2'd0;
	localparam logic [1:0] REASON_MISMATCH = 2'd1;
	localparam logic [1:0] REASON_OPEN     = 2'd2;
	localparam logic [1:0] REASON_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic       is_balanced;
		logic [1:0] fail_reason;
	} out_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [1:0]      kind;
		logic [BT_W-1:0] btype;
		logic            last;
	} cmd_t;

endpackage

[rtl/core/bbc_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/bbc_fifo.sv]
// small flop based queue used between the stages of the checker
// no dependencies
`timescale 1ns / 1ps

module bbc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/bbc_front.sv]
// front stage: classifies each input byte and queues it for the stack engine
// depends on bbc_pkg and bbc_fifo
`timescale 1ns / 1ps

module bbc_front import bbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic cmd_valid,
	input  logic cmd_pop,
	output cmd_t cmd
);

	cmd_t cmd_in;
	logic cmd_empty;

	always_comb begin
		cmd_in.last = item.end_of_string;
		unique case (item.char_byte)
			CH_LPAREN: begin
				cmd_in.kind  = KIND_OPEN;
				cmd_in.btype = BT_PAREN;
			end
			CH_LSQUARE: begin
				cmd_in.kind  = KIND_OPEN;
				cmd_in.btype = BT_SQUARE;
			end
			CH_LCURLY: begin
				cmd_in.kind  = KIND_OPEN;
				cmd_in.btype = BT_CURLY;
			end
			CH_RPAREN: begin
				cmd_in.kind  = KIND_CLOSE;
				cmd_in.btype = BT_PAREN;
			end
			CH_RSQUARE: begin
				cmd_in.kind  = KIND_CLOSE;
				cmd_in.btype = BT_SQUARE;
			end
			CH_RCURLY: begin
				cmd_in.kind  = KIND_CLOSE;
				cmd_in.btype = BT_CURLY;
			end
			default: begin
				cmd_in.kind  = KIND_OTHER;
				cmd_in.btype = BT_PAREN;
			end
		endcase
	end

	bbc_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_Q_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

	assign cmd_valid = ~cmd_empty;

endmodule

[rtl/core/bbc_back.sv]
// back stage: bracket stack engine and result queue
// depends on bbc_pkg, bbc_ram and bbc_fifo
`timescale 1ns / 1ps

module bbc_back import bbc_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  cmd_t cmd,
	output logic empty,
	input  logic pop,
	output out_t result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [DW-1:0]   depth_q;
	logic [BT_W-1:0] top_q;
	logic [1:0]      fail_q;

	logic [DW-1:0]   depth_n;
	logic [BT_W-1:0] top_n;
	logic [1:0]      fail_n;
	logic [1:0]      reason;
	logic [DW-1:0]   below_idx;
	logic [BT_W-1:0] below_data;
	logic            we;
	logic            take;
	logic            res_push;
	logic            res_full;
	out_t            res_in;

	assign take    = cmd_valid & ~res_full;
	assign cmd_pop = take;

	always_comb begin
		depth_n  = depth_q;
		top_n    = top_q;
		fail_n   = fail_q;
		we       = 1'b0;
		res_push = 1'b0;
		reason   = REASON_OK;
		if (take) begin
			if (fail_q == REASON_OK) begin
				unique case (cmd.kind)
					KIND_OPEN: begin
						if (depth_q == DW'(STACK_DEPTH)) begin
							fail_n = REASON_OVERFLOW;
						end else begin
							we      = 1'b1;
							depth_n = depth_q + DW'(1);
							top_n   = cmd.btype;
						end
					end
					KIND_CLOSE: begin
						if (depth_q == '0 || cmd.btype != top_q) begin
							fail_n = REASON_MISMATCH;
						end else begin
							depth_n = depth_q - DW'(1);
							top_n   = below_data;
						end
					end
					default: begin
						fail_n = REASON_MISMATCH;
					end
				endcase
			end
			if (cmd.last) begin
				res_push = 1'b1;
				reason   = fail_n;
				if (fail_n == REASON_OK && depth_n != '0) begin
					reason = REASON_OPEN;
				end
				depth_n = '0;
				fail_n  = REASON_OK;
			end
		end
	end

	// prefetch the entry just below the next top of stack
	assign below_idx = depth_n - DW'(2);

	bbc_ram #(
		.WIDTH(BT_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (we),
		.waddr(depth_q[AW-1:0]),
		.wdata(cmd.btype),
		.raddr(below_idx[AW-1:0]),
		.rdata(below_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			fail_q  <= REASON_OK;
		end else begin
			depth_q <= depth_n;
			fail_q  <= fail_n;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_n;
	end

	assign res_in.is_balanced = (reason == REASON_OK);
	assign res_in.fail_reason = reason;

	bbc_fifo #(
		.WIDTH($bits(out_t)),
		.DEPTH(RES_Q_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

[rtl/core/bracket_balance_checker_core.sv]
// bracket balance checker over a byte stream
// usage:
//   input channel: drive item and push; a beat is taken at a clock edge with
//   push high and full low. item.end_of_string marks the last byte of a string.
//   result channel: while empty is low the oldest result is on result; it is
//   taken at a clock edge with pop high. one result per string, none otherwise.
// result path: a last byte is written into the command queue; the stack engine
//   then takes it and writes its result into the result queue for popping.
// throughput: one byte per cycle unless the result queue is full. the stack
//   engine does one push or pop per cycle; the top of stack sits in a register
//   and the entry under it is prefetched from the single registered ram port.
// reset: both queues empty, stack depth zero, no failure pending. the stack ram
//   is not cleared; only entries below the current depth are ever used.
// stall: a held-off result waits in a two-beat result queue; once that is full
//   the stack engine stops and bytes gather in a four-beat command queue, and
//   full rises when that one is full too.
// depends on bbc_pkg, bbc_front and bbc_back
`timescale 1ns / 1ps

module bracket_balance_checker_core import bbc_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// input channel
	input  logic push,
	output logic full,
	input  in_t  item,
	// result channel
	output logic empty,
	input  logic pop,
	output out_t result
);

	// classified bytes between front and back
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// front: classify and queue each byte
	bbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd)
	);

	// back: stack engine, sticky failure and result queue
	bbc_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

[rtl/core/bbc_checker.sv]
// port level checks for the bracket balance checker core, bound to the top level
// depends on bbc_pkg and bracket_balance_checker_core_macros.svh
`timescale 1ns / 1ps
`include "bracket_balance_checker_core_macros.svh"

module bbc_checker import bbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input in_t  item,
	input logic empty,
	input logic pop,
	input out_t result
);

	localparam int PW = $clog2(CMD_Q_DEPTH + RES_Q_DEPTH + 1);

	// strings ended at the input but not yet popped
	logic [PW-1:0] pending_q;
	logic          last_in;
	logic          res_out;

	assign last_in = push & ~full & item.end_of_string;
	assign res_out = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({last_in, res_out})
				2'b10: pending_q <= pending_q + PW'(1);
				2'b01: pending_q <= pending_q - PW'(1);
				default: pending_q <= pending_q;
			endcase
		end
	end

	`BBC_ASSERT_ALWAYS(a_code_match, empty || (result.is_balanced == (result.fail_reason == REASON_OK)), "is_balanced disagrees with fail_reason")
	`BBC_ASSERT_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(result), "stalled result changed or vanished")
	`BBC_ASSERT_ALWAYS(a_no_phantom, empty || pending_q != '0, "result shown without an ended string")
	`BBC_ASSERT_ALWAYS(a_bounded, pending_q <= PW'(CMD_Q_DEPTH + RES_Q_DEPTH), "more strings in flight than the queues hold")

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.item  (item),
	.empty (empty),
	.pop   (pop),
	.result(result)
);
